@@ hw/rtl/ipv4hc_pkg.sv @@
package ipv4hc_pkg;

  // Number of fixed header bytes that are decoded.
  localparam logic [4:0] HdrBytes   = 5'd20;
  localparam logic [4:0] LastByte   = 5'd19;
  // Byte positions of the received checksum word.
  localparam logic [4:0] CsumHiByte = 5'd10;
  localparam logic [4:0] CsumLoByte = 5'd11;

  // Expected version nibble and the value a verified checksum folds to.
  localparam logic [3:0]  IpVersion4 = 4'd4;
  localparam logic [15:0] CsumGood   = 16'hffff;

  // Bit positions within the status code.
  localparam int unsigned StatBadCsum = 0;
  localparam int unsigned StatBadVer  = 1;

  // Width of the running word sums; ten words never overflow it.
  localparam int unsigned SumW = 20;

  typedef logic [SumW-1:0] sum_t;
  typedef logic [7:0]      byte_t;

  // End-around-carry fold of a 20-bit sum to 16 bits. Two passes suffice:
  // after the first the carry is a single bit and the low half is small.
  function automatic logic [15:0] fold20(input sum_t s);
    logic [16:0] t;
    t = {1'b0, s[15:0]} + {13'b0, s[19:16]};
    return t[15:0] + {15'b0, t[16]};
  endfunction

endpackage

@@ hw/rtl/ipv4_header_parse_check.sv @@
// A header byte accepted into the input register is processed from there; the result for
// the twentieth byte is loaded into the result register when that byte is processed, is
// then shown on the out_ channel and stays there until out_ready takes it.
// Throughput: one byte per cycle, set by the single input register and result register.
// Bytes stall only while a finished result waits for out_ready.
// Reset (rst_n low, synchronous) empties both registers and leaves the parser idle
// until a word with in_start_req set arrives.
module ipv4_header_parse_check import ipv4hc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_hdr_byte,
  input  logic        in_start_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_header_words,
  output logic [7:0]  out_tos_byte,
  output logic [15:0] out_total_length,
  output logic [15:0] out_ident,
  output logic [2:0]  out_frag_flags,
  output logic [12:0] out_frag_offset,
  output logic [7:0]  out_hop_limit,
  output logic [7:0]  out_protocol_num,
  output logic [31:0] out_src_addr,
  output logic [31:0] out_dst_addr,
  output logic [15:0] out_gen_checksum,
  output logic [1:0]  out_status
);

  // Input register.
  logic  in_valid_r, in_valid_nxt;
  byte_t in_byte_r;
  logic  in_start_r;

  // Parser state.
  logic [4:0] byte_count_r, byte_count_nxt;
  sum_t       word_sum_r, word_sum_nxt;   // all words but the checksum word
  sum_t       chk_sum_r, chk_sum_nxt;     // all words including the checksum word
  byte_t      header_store_r [HdrBytes];

  // Result register.
  logic        out_valid_r, out_valid_nxt;
  logic [3:0]  header_words_r;
  logic [7:0]  tos_byte_r;
  logic [15:0] total_length_r;
  logic [15:0] ident_r;
  logic [2:0]  frag_flags_r;
  logic [12:0] frag_offset_r;
  logic [7:0]  hop_limit_r;
  logic [7:0]  protocol_num_r;
  logic [31:0] src_addr_r;
  logic [31:0] dst_addr_r;
  logic [15:0] gen_checksum_r;
  logic [1:0]  status_r;

  // Processing of the registered word.
  logic       slot_free;
  logic       advance;
  logic [4:0] cur_idx;
  sum_t       base_word_sum;
  sum_t       base_chk_sum;
  sum_t       contrib;
  logic       in_header;
  logic       skip_word;
  logic       done;
  logic [1:0] status_nxt;

  // Handshake: the result slot frees when empty or being taken this cycle.
  assign slot_free = !out_valid_r || out_ready;
  assign advance   = in_valid_r && slot_free;
  assign in_ready  = !in_valid_r || slot_free;

  always_comb begin
    // A start flag restarts the count and the sums with this word as byte 0.
    cur_idx       = in_start_r ? 5'd0 : byte_count_r;
    base_word_sum = in_start_r ? '0 : word_sum_r;
    base_chk_sum  = in_start_r ? '0 : chk_sum_r;
    in_header     = (cur_idx < HdrBytes);
    skip_word     = (cur_idx == CsumHiByte) || (cur_idx == CsumLoByte);
    // Even positions are the high byte of a big-endian word.
    contrib       = cur_idx[0] ? {12'b0, in_byte_r} : {4'b0, in_byte_r, 8'b0};

    byte_count_nxt = byte_count_r;
    word_sum_nxt   = word_sum_r;
    chk_sum_nxt    = chk_sum_r;
    done           = 1'b0;
    if (advance && in_header) begin
      byte_count_nxt = cur_idx + 5'd1;
      chk_sum_nxt    = base_chk_sum + contrib;
      word_sum_nxt   = skip_word ? base_word_sum : base_word_sum + contrib;
      done           = (cur_idx == LastByte);
    end else if (advance) begin
      byte_count_nxt = cur_idx;
      word_sum_nxt   = base_word_sum;
      chk_sum_nxt    = base_chk_sum;
    end

    status_nxt = '0;
    status_nxt[StatBadCsum] = (fold20(chk_sum_nxt) != CsumGood);
    status_nxt[StatBadVer]  = (header_store_r[0][7:4] != IpVersion4);

    if (advance && done) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end

    in_valid_nxt = in_ready ? in_valid : in_valid_r;
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      byte_count_r <= HdrBytes;
      word_sum_r   <= '0;
      chk_sum_r    <= '0;
    end else begin
      in_valid_r   <= in_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      byte_count_r <= byte_count_nxt;
      word_sum_r   <= word_sum_nxt;
      chk_sum_r    <= chk_sum_nxt;
    end
  end

  // Input payload register.
  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_byte_r  <= in_hdr_byte;
      in_start_r <= in_start_req;
    end
  end

  // Header byte store.
  always_ff @(posedge clk) begin
    if (advance && in_header) begin
      header_store_r[cur_idx] <= in_byte_r;
    end
  end

  // Result payload; the last destination byte comes straight from the input register.
  always_ff @(posedge clk) begin
    if (advance && done) begin
      header_words_r <= header_store_r[0][3:0];
      tos_byte_r     <= header_store_r[1];
      total_length_r <= {header_store_r[2], header_store_r[3]};
      ident_r        <= {header_store_r[4], header_store_r[5]};
      frag_flags_r   <= header_store_r[6][7:5];
      frag_offset_r  <= {header_store_r[6][4:0], header_store_r[7]};
      hop_limit_r    <= header_store_r[8];
      protocol_num_r <= header_store_r[9];
      src_addr_r     <= {header_store_r[12], header_store_r[13],
                         header_store_r[14], header_store_r[15]};
      dst_addr_r     <= {header_store_r[16], header_store_r[17],
                         header_store_r[18], in_byte_r};
      gen_checksum_r <= ~fold20(word_sum_nxt);
      status_r       <= status_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_header_words = header_words_r;
  assign out_tos_byte     = tos_byte_r;
  assign out_total_length = total_length_r;
  assign out_ident        = ident_r;
  assign out_frag_flags   = frag_flags_r;
  assign out_frag_offset  = frag_offset_r;
  assign out_hop_limit    = hop_limit_r;
  assign out_protocol_num = protocol_num_r;
  assign out_src_addr     = src_addr_r;
  assign out_dst_addr     = dst_addr_r;
  assign out_gen_checksum = gen_checksum_r;
  assign out_status       = status_r;

endmodule

@@ hw/rtl/ipv4hc_checker.sv @@
module ipv4hc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_dst_addr,
  input logic [15:0] out_gen_checksum,
  input logic [1:0]  out_status
);

  // After reset no result is shown and a word can be taken at once.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result shown or input blocked after reset");

  // The input side only stalls behind a result that is waiting to be taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

  // A waiting result holds its word.
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_dst_addr) && $stable(out_gen_checksum) && $stable(out_status))
    else $error("waiting result changed or dropped");

  // A result leaves only when it is taken.
  a_result_taken: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) && $past(rst_n) |-> $past(out_ready))
    else $error("result dropped without being taken");

endmodule

bind ipv4_header_parse_check ipv4hc_checker u_ipv4hc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_dst_addr     (out_dst_addr),
  .out_gen_checksum (out_gen_checksum),
  .out_status       (out_status)
);
